// ===== rtl/kvls_pkg.sv =====
`default_nettype none

package kvls_pkg;

	localparam int DATA_W       = 32;
	localparam int IDX_W        = 6;
	localparam int CNT_W        = 7;
	localparam int FRAC_W       = 16;
	localparam int QUO_W        = FRAC_W + 1;
	localparam int DIV_CNT_W    = $clog2(QUO_W);
	localparam int MAX_KEYS_DEF = 64;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic [1:0] COMP_X = 2'd0;
	localparam logic [1:0] COMP_Y = 2'd1;
	localparam logic [1:0] COMP_Z = 2'd2;

	typedef enum logic [1:0] {
		RES_HOLD,
		RES_PREV,
		RES_CUR
	} res_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             mem_wr;
		logic             load_query;
		logic             rd_en;
		logic             shift_prev;
		logic             div_init;
		logic             div_step;
		logic             div_shift;
		logic             mul;
		logic             add;
		logic [1:0]       comp;
		res_sel_t         res_sel;
		logic             seg_load;
		logic [IDX_W-1:0] res_seg;
	} dp_cmd_t;

	// Compare results from the datapath.
	typedef struct packed {
		logic q_le_cur;
		logic bracket;
		logic zero_len;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/kvls_ifs.sv =====
`default_nettype none

interface kvls_req_if import kvls_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [IDX_W-1:0]  key_index;
	logic [DATA_W-1:0] key_time;
	logic signed [DATA_W-1:0] key_x;
	logic signed [DATA_W-1:0] key_y;
	logic signed [DATA_W-1:0] key_z;
	logic [DATA_W-1:0] query_time;

	modport source (output valid, req_type, key_index, key_time, key_x, key_y, key_z,
		query_time, input ready);
	modport sink (input valid, req_type, key_index, key_time, key_x, key_y, key_z,
		query_time, output ready);
endinterface

interface kvls_rsp_if import kvls_pkg::*; ();
	logic              valid;
	logic              ready;
	logic signed [DATA_W-1:0] out_x;
	logic signed [DATA_W-1:0] out_y;
	logic signed [DATA_W-1:0] out_z;
	logic [IDX_W-1:0]  segment_start;

	modport source (output valid, out_x, out_y, out_z, segment_start, input ready);
	modport sink (input valid, out_x, out_y, out_z, segment_start, output ready);
endinterface

interface kvls_cfg_if import kvls_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] key_count;

	modport source (output valid, key_count, input ready);
	modport sink (input valid, key_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/kvls_ctrl.sv =====
`default_nettype none

module kvls_ctrl import kvls_pkg::*; #(
	parameter int MAX_KEYS = MAX_KEYS_DEF,
	localparam int AW = $clog2(MAX_KEYS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire logic             req_type,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	input  wire logic             cfg_valid,
	input  wire logic [CNT_W-1:0] cfg_key_count,
	output logic                  cfg_ready,
	input  wire dp_stat_t         stat,
	output dp_cmd_t               cmd,
	output logic [AW-1:0]         rd_addr
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIRST,
		S_SCAN,
		S_DIV,
		S_MUL,
		S_ADD,
		S_OUT
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        seg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [1:0]           comp_q;
	logic [CNT_W-1:0]     kc_q;

	logic [AW-1:0] last_idx;
	logic [AW:0]   seg_p1;
	logic [AW:0]   seg_p2;
	logic          seg_is_last;
	logic          accept;
	logic          first_done;

	// Index of the last key in use; a count of zero means one key.
	always_comb begin
		if (kc_q == '0) begin
			last_idx = '0;
		end else if (32'(kc_q) > 32'(MAX_KEYS)) begin
			last_idx = AW'(MAX_KEYS - 1);
		end else begin
			last_idx = AW'(kc_q - 1'b1);
		end
	end

	assign seg_p1      = {1'b0, seg_q} + (AW+1)'(1);
	assign seg_p2      = {1'b0, seg_q} + (AW+1)'(2);
	assign seg_is_last = (seg_p1 == {1'b0, last_idx});
	assign first_done  = (last_idx == '0) || stat.q_le_cur;

	assign req_ready = (state_q == S_IDLE) || ((state_q == S_OUT) && rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = (state_q == S_OUT);
	assign cfg_ready = 1'b1;

	always_comb begin
		cmd     = '0;
		rd_addr = '0;
		case (state_q)
			S_IDLE, S_OUT: begin
				if (accept) begin
					if (req_type == REQ_WRITE) begin
						cmd.mem_wr = 1'b1;
					end else begin
						cmd.load_query = 1'b1;
						cmd.rd_en      = 1'b1;
					end
				end
			end
			S_FIRST: begin
				if (first_done) begin
					cmd.res_sel  = RES_CUR;
					cmd.seg_load = 1'b1;
				end else begin
					cmd.shift_prev = 1'b1;
					cmd.rd_en      = 1'b1;
					rd_addr        = AW'(1);
				end
			end
			S_SCAN: begin
				if (stat.bracket) begin
					cmd.seg_load = 1'b1;
					cmd.res_seg  = IDX_W'(seg_q);
					if (stat.zero_len) begin
						cmd.res_sel = RES_PREV;
					end else begin
						cmd.div_init = 1'b1;
					end
				end else if (seg_is_last) begin
					cmd.res_sel  = RES_CUR;
					cmd.seg_load = 1'b1;
					cmd.res_seg  = IDX_W'(last_idx);
				end else begin
					cmd.shift_prev = 1'b1;
					cmd.rd_en      = 1'b1;
					rd_addr        = seg_p2[AW-1:0];
				end
			end
			S_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_shift = (cnt_q != '0);
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				cmd.comp = comp_q;
			end
			S_ADD: begin
				cmd.add  = 1'b1;
				cmd.comp = comp_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seg_q   <= '0;
			cnt_q   <= '0;
			comp_q  <= COMP_X;
			kc_q    <= CNT_W'(1);
		end else begin
			if (cfg_valid) begin
				kc_q <= cfg_key_count;
			end
			case (state_q)
				S_IDLE, S_OUT: begin
					if (accept) begin
						state_q <= (req_type == REQ_SAMPLE) ? S_FIRST : S_IDLE;
					end else if (state_q == S_OUT && rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_FIRST: begin
					seg_q <= '0;
					state_q <= first_done ? S_OUT : S_SCAN;
				end
				S_SCAN: begin
					if (stat.bracket) begin
						cnt_q   <= '0;
						state_q <= stat.zero_len ? S_OUT : S_DIV;
					end else if (seg_is_last) begin
						state_q <= S_OUT;
					end else begin
						seg_q <= seg_p1[AW-1:0];
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
						comp_q  <= COMP_X;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (comp_q == COMP_Z) begin
						state_q <= S_OUT;
					end else begin
						comp_q  <= comp_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/kvls_dp.sv =====
`default_nettype none

module kvls_dp import kvls_pkg::*; #(
	parameter int MAX_KEYS = MAX_KEYS_DEF,
	localparam int AW = $clog2(MAX_KEYS)
) (
	input  wire logic                     clk,
	input  wire dp_cmd_t                  cmd,
	input  wire logic [AW-1:0]            rd_addr,
	input  wire logic [IDX_W-1:0]         key_index,
	input  wire logic [DATA_W-1:0]        key_time,
	input  wire logic signed [DATA_W-1:0] key_x,
	input  wire logic signed [DATA_W-1:0] key_y,
	input  wire logic signed [DATA_W-1:0] key_z,
	input  wire logic [DATA_W-1:0]        query_time,
	output dp_stat_t                      stat,
	output logic signed [DATA_W-1:0]      out_x,
	output logic signed [DATA_W-1:0]      out_y,
	output logic signed [DATA_W-1:0]      out_z,
	output logic [IDX_W-1:0]              segment_start
);

	localparam int ENT_W  = 4 * DATA_W;
	localparam int PROD_W = DATA_W + 1 + QUO_W + 1;

	// Entry layout: time, x, y, z from the top bits down.
	logic [ENT_W-1:0] mem [MAX_KEYS];

	logic [ENT_W-1:0]  rd_q;
	logic [ENT_W-1:0]  prev_q;
	logic [DATA_W-1:0] query_q;
	logic [DATA_W-1:0] dt_q;
	logic [DATA_W:0]   rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic signed [DATA_W:0]   diff_q [3];
	logic signed [PROD_W-1:0] prod_q;
	logic [DATA_W-1:0] res_q [3];
	logic [IDX_W-1:0]  seg_q;

	logic [DATA_W-1:0] cur_t;
	logic [DATA_W-1:0] prev_t;
	logic [DATA_W-1:0] cur_v [3];
	logic [DATA_W-1:0] prev_v [3];
	logic [DATA_W:0]   cand;
	logic signed [DATA_W:0] diff_sel;
	logic [DATA_W-1:0] base_sel;

	assign cur_t  = rd_q[ENT_W-1 -: DATA_W];
	assign prev_t = prev_q[ENT_W-1 -: DATA_W];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			cur_v[c]  = rd_q[(2-c)*DATA_W +: DATA_W];
			prev_v[c] = prev_q[(2-c)*DATA_W +: DATA_W];
		end
	end

	assign stat.q_le_cur = (query_q <= cur_t);
	assign stat.bracket  = (prev_t <= query_q) && (query_q <= cur_t);
	assign stat.zero_len = (cur_t == prev_t);

	always_comb begin
		case (cmd.comp)
			COMP_X: begin
				diff_sel = diff_q[0];
				base_sel = prev_v[0];
			end
			COMP_Y: begin
				diff_sel = diff_q[1];
				base_sel = prev_v[1];
			end
			default: begin
				diff_sel = diff_q[2];
				base_sel = prev_v[2];
			end
		endcase
	end

	assign cand = cmd.div_shift ? {rem_q[DATA_W-1:0], 1'b0} : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && (32'(key_index) < 32'(MAX_KEYS))) begin
			mem[AW'(key_index)] <= {key_time, key_x, key_y, key_z};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			query_q <= query_time;
		end
		if (cmd.shift_prev) begin
			prev_q <= rd_q;
		end

		// Restoring division; the remainder starts at or below the divisor.
		if (cmd.div_init) begin
			dt_q  <= cur_t - prev_t;
			rem_q <= {1'b0, query_q - prev_t};
			quo_q <= '0;
			for (int c = 0; c < 3; c++) begin
				diff_q[c] <= $signed({cur_v[c][DATA_W-1], cur_v[c]})
					- $signed({prev_v[c][DATA_W-1], prev_v[c]});
			end
		end else if (cmd.div_step) begin
			if (cand >= {1'b0, dt_q}) begin
				rem_q <= cand - {1'b0, dt_q};
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= cand;
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end

		if (cmd.mul) begin
			prod_q <= diff_sel * $signed({1'b0, quo_q});
		end

		// The arithmetic shift of the product floors toward minus infinity.
		if (cmd.add) begin
			case (cmd.comp)
				COMP_X: res_q[0] <= base_sel + prod_q[FRAC_W +: DATA_W];
				COMP_Y: res_q[1] <= base_sel + prod_q[FRAC_W +: DATA_W];
				COMP_Z: res_q[2] <= base_sel + prod_q[FRAC_W +: DATA_W];
				default: begin
				end
			endcase
		end else begin
			case (cmd.res_sel)
				RES_PREV: res_q <= prev_v;
				RES_CUR:  res_q <= cur_v;
				default: begin
				end
			endcase
		end

		if (cmd.seg_load) begin
			seg_q <= cmd.res_seg;
		end
	end

	assign out_x         = res_q[0];
	assign out_y         = res_q[1];
	assign out_z         = res_q[2];
	assign segment_start = seg_q;

endmodule

`default_nettype wire

// ===== rtl/keyframe_vector_lerp_sampler_unit.sv =====
// Write items return nothing. A sample result comes from key 0 when that key is used,
// from a held key when one ends the scan at segment i, and is interpolated on segment i
// when that segment brackets the query (17 divider steps, then a multiply and an add per
// component). The key scan reads one table entry per cycle. The next item is taken in the
// cycle the result transfers. Reset is asynchronous: it clears the controller and sets
// the key count to one; the key table is not cleared.
`default_nettype none

module keyframe_vector_lerp_sampler_unit import kvls_pkg::*; #(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	kvls_req_if.sink    req,
	kvls_rsp_if.source  rsp,
	kvls_cfg_if.sink    cfg
);

	localparam int AW = $clog2(MAX_KEYS);

	// The controller and the datapath talk only through these two groups, plus the
	// table read address, whose width follows the table depth.
	dp_cmd_t       cmd;
	dp_stat_t      stat;
	logic [AW-1:0] rd_addr;

	// The controller owns the key count register, the scan index and the divider
	// and blend counters. It drives req.ready and rsp.valid from its state.
	kvls_ctrl #(
		.MAX_KEYS(MAX_KEYS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_type      (req.req_type),
		.req_ready     (req.ready),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.cfg_valid     (cfg.valid),
		.cfg_key_count (cfg.key_count),
		.cfg_ready     (cfg.ready),
		.stat          (stat),
		.cmd           (cmd),
		.rd_addr       (rd_addr)
	);

	// The datapath holds the key table, the previous and current entries of the
	// scan, the serial divider, the shared multiplier and the result registers.
	kvls_dp #(
		.MAX_KEYS(MAX_KEYS)
	) u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.key_index     (req.key_index),
		.key_time      (req.key_time),
		.key_x         (req.key_x),
		.key_y         (req.key_y),
		.key_z         (req.key_z),
		.query_time    (req.query_time),
		.stat          (stat),
		.out_x         (rsp.out_x),
		.out_y         (rsp.out_y),
		.out_z         (rsp.out_z),
		.segment_start (rsp.segment_start)
	);

	// A pending result that is not being taken blocks new input transfers.
	a_no_accept_while_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !(req.valid && req.ready))
		else $error("input transfer while a result was held");

	// A write transfer never produces a result.
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.req_type == REQ_WRITE)) |=> !rsp.valid)
		else $error("result appeared after a write transfer");

	// A sample needs at least one table read before its result can appear.
	a_sample_not_immediate: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.req_type == REQ_SAMPLE)) |=> !rsp.valid)
		else $error("sample result appeared without a table read");

endmodule

`default_nettype wire
